// ===== src/cnef_pkg.sv =====
package cnef_pkg;

   // Coordinate format and the product of a coordinate with the cell scale.
   localparam int COORD_FRAC_BITS = 16;
   localparam int COORD_W = 32;
   localparam int SCALE_W = 19;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 19'd65536;
   localparam int FBITS = COORD_FRAC_BITS + 16;
   localparam int PROD_W = 52;
   localparam int Q24_W = 24;
   localparam int CELL_ONE = 1 << Q24_W;

   // Integer hash multipliers and salts.
   localparam logic [31:0] HASH_K1 = 32'h9e3779b9;
   localparam logic [31:0] HASH_K2 = 32'h85ebca6b;
   localparam logic [31:0] HASH_K3 = 32'h7feb352d;
   localparam logic [31:0] HASH_K4 = 32'h846ca68b;
   localparam logic [31:0] SALT_FX = 32'h68bc21eb;
   localparam logic [31:0] SALT_FY = 32'h02e5be93;
   localparam logic [31:0] SALT_REGION = 32'ha511e9b3;

   // Feature points and distances.
   localparam int NCAND = 9;
   localparam logic [Q24_W-1:0] OFF_BASE = 24'd2013266;
   localparam logic [Q24_W-1:0] OFF_SPAN = 24'd12750684;
   localparam int DIFF_W = 27;
   localparam int SQ_W = 50;
   localparam int DIST_W = 51;

   // Pipelined square root: two result bits per stage.
   localparam int ROOT_W = 26;
   localparam int RAD_W = 2 * ROOT_W;
   localparam int REM_W = ROOT_W + 2;
   localparam int SQRT_STEPS = 2;
   localparam int SQRT_STAGES = ROOT_W / SQRT_STEPS;

   // Transition ramp and blend.
   localparam logic [ROOT_W-1:0] GAP = 26'd301990;
   localparam int RAMP_W = 21;
   localparam logic [RAMP_W-1:0] RAMP_DEN = 21'd2013266;
   localparam int RECIP_W = 36;
   localparam int RECIP_SHIFT = 40;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << 56) / 64'd2013266);
   localparam int T_W = 17;
   localparam logic [T_W-1:0] T_ONE = 17'd65536;
   localparam int REGION_W = 25;
   localparam logic [REGION_W-1:0] QUARTER = 25'd4194304;
   localparam logic [REGION_W-1:0] REGION_SPAN = 25'd23488102;
   localparam int FIELD_W = 16;
   localparam logic signed [FIELD_W-1:0] DARK_LEVEL = -16'sd31130;
   localparam logic signed [FIELD_W-1:0] FIELD_MIN = -16'sd31130;
   localparam logic signed [FIELD_W-1:0] FIELD_MAX = 16'sd22938;

   // Pipeline positions.
   localparam int HASH_LAT = 3;
   localparam int CTX_LEN = 9;
   localparam int FX_TAP = 3;
   localparam int R_DLY = 10;
   localparam int SRCH_LAST = 9;
   localparam int ROOT_LAST = 22;
   localparam int LATENCY = 30;

   typedef struct packed {
      logic [COORD_W-1:0] cx0;
      logic [COORD_W-1:0] cy0;
      logic [Q24_W-1:0]   fx;
      logic [Q24_W-1:0]   fy;
   } ctx_type;

   typedef struct packed {
      logic [DIST_W-1:0] d1;
      logic [DIST_W-1:0] d2;
      logic signed [1:0] best_ox;
      logic signed [1:0] best_oy;
   } srch_type;

   // Feature offset inside a cell: 0.12 + 0.76 * u in Q0.24.
   function automatic logic [Q24_W-1:0] feat_off(input logic [31:0] h);
      logic [2*Q24_W-1:0] prod;
      prod = (2*Q24_W)'(h[31:8]) * (2*Q24_W)'(OFF_SPAN);
      return OFF_BASE + prod[2*Q24_W-1:Q24_W];
   endfunction

   // Region level above the edge level: 0.25 + 1.40 * u in Q.24.
   function automatic logic [REGION_W-1:0] region_level(input logic [31:0] h);
      logic [Q24_W+REGION_W-1:0] prod;
      prod = (Q24_W+REGION_W)'(h[31:8]) * (Q24_W+REGION_W)'(REGION_SPAN);
      return QUARTER + prod[Q24_W+REGION_W-1:Q24_W];
   endfunction

   // Nearest and second-nearest update; ties keep the earlier candidate.
   function automatic srch_type srch_update(input srch_type s, input logic [DIST_W-1:0] dd,
                                            input logic signed [1:0] ox,
                                            input logic signed [1:0] oy);
      srch_type r;
      r = s;
      if (dd < s.d1) begin
         r.d2 = s.d1;
         r.d1 = dd;
         r.best_ox = ox;
         r.best_oy = oy;
      end else if (dd < s.d2) begin
         r.d2 = dd;
      end
      return r;
   endfunction

endpackage

// ===== src/cnef_hash.sv =====
module cnef_hash (
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] cell_x,
   input  logic [31:0] cell_y,
   input  logic [31:0] salt,
   output logic [31:0] hash
);
   import cnef_pkg::*;

   logic [31:0] m1, m2, m3;
   logic [31:0] mix_in, mix_ff;
   logic [31:0] mul_in, mul_ff;
   logic [31:0] fin_in, fin_ff;

   // Three rounds, a register after every round; the first round has two multiplies, the others one each.
   always_comb begin
      m1 = (cell_x * HASH_K1) ^ (cell_y * HASH_K2) ^ salt;
      mix_in = m1 ^ (m1 >> 16);
      m2 = mix_ff * HASH_K3;
      mul_in = m2 ^ (m2 >> 15);
      m3 = mul_ff * HASH_K4;
      fin_in = m3 ^ (m3 >> 16);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mix_ff <= mix_in;
         mul_ff <= mul_in;
         fin_ff <= fin_in;
      end
   end

   assign hash = fin_ff;

endmodule

// ===== src/cnef_isqrt.sv =====
module cnef_isqrt (
   input  logic                          clock,
   input  logic                          en,
   input  logic [cnef_pkg::DIST_W-1:0]   radicand,
   output logic [cnef_pkg::ROOT_W-1:0]   root
);
   import cnef_pkg::*;

   typedef struct packed {
      logic [RAD_W-1:0]  rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sq_state_type;

   sq_state_type src [SQRT_STAGES];
   sq_state_type st_in [SQRT_STAGES];
   sq_state_type st_ff [SQRT_STAGES];

   // Digit-by-digit floor root, one result bit per step.
   function automatic sq_state_type sqrt_steps(input sq_state_type s);
      sq_state_type r;
      logic [REM_W+1:0] acc;
      logic [REM_W+1:0] trial;
      r = s;
      for (int i = 0; i < SQRT_STEPS; i++) begin
         acc = {r.rem, r.rad[RAD_W-1 -: 2]};
         trial = (REM_W+2)'({r.root, 2'b01});
         r.rad = r.rad << 2;
         if (acc >= trial) begin
            r.rem = REM_W'(acc - trial);
            r.root = {r.root[ROOT_W-2:0], 1'b1};
         end else begin
            r.rem = REM_W'(acc);
            r.root = {r.root[ROOT_W-2:0], 1'b0};
         end
      end
      return r;
   endfunction

   // First stage starts from the padded radicand.
   always_comb begin
      src[0].rad = RAD_W'(radicand);
      src[0].rem = '0;
      src[0].root = '0;
      for (int s = 1; s < SQRT_STAGES; s++) begin
         src[s] = st_ff[s-1];
      end
      for (int s = 0; s < SQRT_STAGES; s++) begin
         st_in[s] = sqrt_steps(src[s]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < SQRT_STAGES; s++) begin
            st_ff[s] <= st_in[s];
         end
      end
   end

   assign root = st_ff[SQRT_STAGES-1].root;

endmodule

// ===== src/cnef_ramp.sv =====
module cnef_ramp (
   input  logic                            clock,
   input  logic                            en,
   input  logic [cnef_pkg::ROOT_W-1:0]     root_near,
   input  logic [cnef_pkg::ROOT_W-1:0]     root_far,
   input  logic [cnef_pkg::REGION_W-1:0]   region,
   output logic [cnef_pkg::FIELD_W-1:0]    field_value
);
   import cnef_pkg::*;

   localparam int PQ_W = RAMP_W + RECIP_W;
   localparam int NUM_W = RAMP_W + 17;
   localparam int RE_W = REGION_W + T_W;

   typedef struct packed {
      logic zero;
      logic full;
   } mode_type;

   logic [ROOT_W-1:0]   sep, n_wide;
   mode_type            mode_in, mode_ff, mode2_ff;
   logic [RAMP_W-1:0]   n_in, n_ff, n2_ff;
   logic [PQ_W-1:0]     pq_in, pq_ff;
   logic [T_W-1:0]      q0, t_in, t_ff, t3_ff;
   logic [NUM_W-1:0]    num, qr, rem;
   logic [2*T_W-1:0]    tt;
   logic [T_W-1:0]      t2_in, t2_ff;
   logic [T_W:0]        w;
   logic [2*T_W:0]      ew;
   logic [T_W-1:0]      e_in, e_ff;
   logic [RE_W-1:0]     re_in, re_ff;
   logic [RE_W:0]       rnd;
   logic [FIELD_W-1:0]  fv_in, fv_ff;
   logic [REGION_W-1:0] r_ff [5];

   always_comb begin
      // Root difference past the gap, with the flat and saturated ends flagged.
      sep = root_far - root_near;
      n_wide = sep - GAP;
      mode_in.zero = (sep <= GAP);
      mode_in.full = !mode_in.zero && (n_wide >= ROOT_W'(RAMP_DEN));
      n_in = n_wide[RAMP_W-1:0];
      // Quotient estimate by reciprocal.
      pq_in = PQ_W'(n_ff) * PQ_W'(RECIP);
      // One correction step, then the clamp.
      q0 = pq_ff[RECIP_SHIFT +: T_W];
      num = {n2_ff, 17'd0} >> 1;
      qr = NUM_W'(q0) * NUM_W'(RAMP_DEN);
      rem = num - qr;
      priority if (mode2_ff.zero) begin
         t_in = '0;
      end else if (mode2_ff.full) begin
         t_in = T_ONE;
      end else if (rem >= NUM_W'(RAMP_DEN)) begin
         t_in = q0 + T_W'(1);
      end else begin
         t_in = q0;
      end
      // Smoothstep: t^2 (3 - 2t).
      tt = (2*T_W)'(t_ff) * (2*T_W)'(t_ff);
      t2_in = tt[16 +: T_W];
      w = (T_W+1)'(196608) - {t3_ff, 1'b0};
      ew = (2*T_W+1)'(t2_ff) * (2*T_W+1)'(w);
      e_in = ew[16 +: T_W];
      // Blend toward the region level, rounded half up to Q1.15.
      re_in = RE_W'(r_ff[4]) * RE_W'(e_ff);
      rnd = (RE_W+1)'(re_ff) + (RE_W+1)'(1 << 24);
      fv_in = DARK_LEVEL + rnd[25 +: FIELD_W];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mode_ff <= mode_in;
         n_ff <= n_in;
         mode2_ff <= mode_ff;
         n2_ff <= n_ff;
         pq_ff <= pq_in;
         t_ff <= t_in;
         t3_ff <= t_ff;
         t2_ff <= t2_in;
         e_ff <= e_in;
         re_ff <= re_in;
         fv_ff <= fv_in;
         r_ff[0] <= region;
         for (int i = 1; i < 5; i++) begin
            r_ff[i] <= r_ff[i-1];
         end
      end
   end

   assign field_value = fv_ff;

endmodule

// ===== src/cellular_noise_edge_field_core.sv =====
// Cellular edge field (F2 minus F1) over a 3x3 cell neighborhood, fully pipelined.
// Throughput: one beat per cycle unless the response stalls; the 13-stage square roots and hash rounds set the depth.
// A stalled response holds the whole pipeline; nothing is dropped or repeated.
// Reset (synchronous, active high) clears all valid bits and sets cell_scale to 1.0.
module cellular_noise_edge_field_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // world_x [31:0], world_y [63:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // field_value [15:0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [18:0] csr_data     // cell_scale [18:0]
);
   import cnef_pkg::*;

   logic                    en;
   logic [SCALE_W-1:0]      scale_in, scale_ff;
   logic [LATENCY-1:0]      vld_in, vld_ff;
   logic [PROD_W-1:0]       px_in, py_in, px_ff, py_ff;
   logic [COORD_W-1:0]      cx0, cy0;
   ctx_type                 ctx_in, ctx_ff [CTX_LEN];
   logic [31:0]             hx [NCAND];
   logic [31:0]             hy [NCAND];
   logic [Q24_W-1:0]        offx_in [NCAND], offy_in [NCAND];
   logic [Q24_W-1:0]        offx_ff [NCAND], offy_ff [NCAND];
   logic [SQ_W-1:0]         sqx_in [NCAND], sqy_in [NCAND];
   logic [SQ_W-1:0]         sqx_ff [NCAND], sqy_ff [NCAND];
   logic [DIST_W-1:0]       dd_in [NCAND], dd_ff [NCAND];
   logic [DIST_W-1:0]       ddq1_ff [NCAND], ddq2_ff [NCAND];
   srch_type                srch_in [3], srch_ff [3];
   logic [COORD_W-1:0]      bx, by;
   logic [31:0]             hr;
   logic [REGION_W-1:0]     rq_ff [R_DLY];
   logic [ROOT_W-1:0]       root_near, root_far;
   logic [FIELD_W-1:0]      field_value;

   // The pipeline moves whenever the output register is free or being taken.
   assign en = !vld_ff[LATENCY-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[LATENCY-1];
   assign rsp_tdata = field_value;
   assign csr_ready = 1'b1;

   // Scale register and valid line.
   always_comb begin
      scale_in = csr_valid ? csr_data : scale_ff;
      vld_in = {vld_ff[LATENCY-2:0], req_tvalid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
         vld_ff <= '0;
      end else begin
         scale_ff <= scale_in;
         if (en) begin
            vld_ff <= vld_in;
         end
      end
   end

   // Scaled coordinates: the floor gives the cell, the fraction is kept in Q0.24.
   always_comb begin
      px_in = {{(PROD_W-COORD_W){req_tdata[31]}}, req_tdata[31:0]}
            * {{(PROD_W-SCALE_W){1'b0}}, scale_ff};
      py_in = {{(PROD_W-COORD_W){req_tdata[63]}}, req_tdata[63:32]}
            * {{(PROD_W-SCALE_W){1'b0}}, scale_ff};
      cx0 = COORD_W'($signed(px_ff[PROD_W-1:FBITS]));
      cy0 = COORD_W'($signed(py_ff[PROD_W-1:FBITS]));
      ctx_in.cx0 = cx0;
      ctx_in.cy0 = cy0;
      ctx_in.fx = px_ff[FBITS-1 -: Q24_W];
      ctx_in.fy = py_ff[FBITS-1 -: Q24_W];
   end

   // One lane per neighbor cell, visited row by row.
   for (genvar g = 0; g < NCAND; g++) begin : g_lane
      localparam int OX = (g % 3) - 1;
      localparam int OY = (g / 3) - 1;
      localparam logic signed [DIFF_W-1:0] X_BIAS = DIFF_W'(OX * CELL_ONE);
      localparam logic signed [DIFF_W-1:0] Y_BIAS = DIFF_W'(OY * CELL_ONE);
      logic signed [DIFF_W-1:0]   dx, dy;
      logic signed [2*DIFF_W-1:0] sx, sy;

      cnef_hash u_hash_x (
         .clock  (clock),
         .en     (en),
         .cell_x (cx0 + COORD_W'(OX)),
         .cell_y (cy0 + COORD_W'(OY)),
         .salt   (SALT_FX),
         .hash   (hx[g])
      );

      cnef_hash u_hash_y (
         .clock  (clock),
         .en     (en),
         .cell_x (cx0 + COORD_W'(OX)),
         .cell_y (cy0 + COORD_W'(OY)),
         .salt   (SALT_FY),
         .hash   (hy[g])
      );

      // Feature offset, then the squared distance to the sample point.
      always_comb begin
         offx_in[g] = feat_off(hx[g]);
         offy_in[g] = feat_off(hy[g]);
         dx = X_BIAS + $signed(DIFF_W'(offx_ff[g])) - $signed(DIFF_W'(ctx_ff[FX_TAP].fx));
         dy = Y_BIAS + $signed(DIFF_W'(offy_ff[g])) - $signed(DIFF_W'(ctx_ff[FX_TAP].fy));
         sx = dx * dx;
         sy = dy * dy;
         sqx_in[g] = sx[SQ_W-1:0];
         sqy_in[g] = sy[SQ_W-1:0];
         dd_in[g] = DIST_W'(sqx_ff[g]) + DIST_W'(sqy_ff[g]);
      end
   end

   // Nearest and second-nearest search, three candidates per stage.
   always_comb begin
      srch_in[0].d1 = '1;
      srch_in[0].d2 = '1;
      srch_in[0].best_ox = '0;
      srch_in[0].best_oy = '0;
      for (int k = 0; k < 3; k++) begin
         srch_in[0] = srch_update(srch_in[0], dd_ff[k], 2'(k - 1), -2'sd1);
      end
      srch_in[1] = srch_ff[0];
      for (int k = 0; k < 3; k++) begin
         srch_in[1] = srch_update(srch_in[1], ddq1_ff[3 + k], 2'(k - 1), 2'sd0);
      end
      srch_in[2] = srch_ff[1];
      for (int k = 0; k < 3; k++) begin
         srch_in[2] = srch_update(srch_in[2], ddq2_ff[6 + k], 2'(k - 1), 2'sd1);
      end
      bx = ctx_ff[CTX_LEN-1].cx0 + COORD_W'(srch_ff[2].best_ox);
      by = ctx_ff[CTX_LEN-1].cy0 + COORD_W'(srch_ff[2].best_oy);
   end

   // Payload stages.
   always_ff @(posedge clock) begin
      if (en) begin
         px_ff <= px_in;
         py_ff <= py_in;
         ctx_ff[0] <= ctx_in;
         for (int i = 1; i < CTX_LEN; i++) begin
            ctx_ff[i] <= ctx_ff[i-1];
         end
         for (int g = 0; g < NCAND; g++) begin
            offx_ff[g] <= offx_in[g];
            offy_ff[g] <= offy_in[g];
            sqx_ff[g] <= sqx_in[g];
            sqy_ff[g] <= sqy_in[g];
            dd_ff[g] <= dd_in[g];
            ddq1_ff[g] <= dd_ff[g];
            ddq2_ff[g] <= ddq1_ff[g];
         end
         for (int s = 0; s < 3; s++) begin
            srch_ff[s] <= srch_in[s];
         end
         rq_ff[0] <= region_level(hr);
         for (int i = 1; i < R_DLY; i++) begin
            rq_ff[i] <= rq_ff[i-1];
         end
      end
   end

   // Region level of the nearest cell.
   cnef_hash u_hash_region (
      .clock  (clock),
      .en     (en),
      .cell_x (bx),
      .cell_y (by),
      .salt   (SALT_REGION),
      .hash   (hr)
   );

   cnef_isqrt u_root_near (
      .clock    (clock),
      .en       (en),
      .radicand (srch_ff[2].d1),
      .root     (root_near)
   );

   cnef_isqrt u_root_far (
      .clock    (clock),
      .en       (en),
      .radicand (srch_ff[2].d2),
      .root     (root_far)
   );

   cnef_ramp u_ramp (
      .clock       (clock),
      .en          (en),
      .root_near   (root_near),
      .root_far    (root_far),
      .region      (rq_ff[R_DLY-1]),
      .field_value (field_value)
   );

`ifndef ASSERT_OFF
   a_search_order: assert property (@(posedge clock) disable iff (reset)
      vld_ff[SRCH_LAST] |-> (srch_ff[2].d1 <= srch_ff[2].d2))
      else $error("nearest distance exceeds second-nearest distance");

   a_root_order: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ROOT_LAST] |-> (root_near <= root_far))
      else $error("nearest root exceeds second-nearest root");

   a_field_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (($signed(rsp_tdata) >= FIELD_MIN) && ($signed(rsp_tdata) <= FIELD_MAX)))
      else $error("field value out of range");
`endif

endmodule

// ===== verif/testbench.sv =====
module testbench;
   import cnef_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [18:0] csr_data = '0;

   cellular_noise_edge_field_core u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #2 clock = ~clock;

   // Predictor copy of the scale register and the queue of expected field values.
   logic [18:0]       model_scale = SCALE_RESET;
   logic signed [15:0] field_queue[$];
   int  errors = 0;
   int  sent = 0;
   int  received = 0;
   int  idle_cycles = 0;
   bit  rsp_hold = 1'b0;
   bit  calm = 1'b0;

   function automatic logic [31:0] mix_hash(input logic [31:0] cx, input logic [31:0] cy,
                                            input logic [31:0] salt);
      logic [31:0] v;
      v = (cx * 32'h9e3779b9) ^ (cy * 32'h85ebca6b) ^ salt;
      v = v ^ (v >> 16);
      v = v * 32'h7feb352d;
      v = v ^ (v >> 15);
      v = v * 32'h846ca68b;
      return v ^ (v >> 16);
   endfunction

   function automatic longint unsigned isqrt(input longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic longint place_offset(input logic [31:0] h);
      longint unsigned u;
      u = h[31:8];
      return 64'd2013266 + ((u * 64'd12750684) >> 24);
   endfunction

   // Splits a scaled coordinate into its cell and the Q0.24 position inside it.
   function automatic void split_coord(input logic [31:0] coord, input logic [18:0] scale,
                                       output logic [31:0] cell_idx, output longint frac);
      longint p;
      p = longint'($signed(coord)) * longint'({1'b0, scale});
      cell_idx = 32'(p >>> 32);
      frac = longint'((p & 64'hFFFF_FFFF) >> 8);
   endfunction

   function automatic logic signed [15:0] predict_field(input logic [31:0] wx,
                                                        input logic [31:0] wy);
      logic [31:0] cx0, cy0, cx, cy, bx, by;
      longint fx, fy, dx, dy;
      longint unsigned d1, d2, dd, sep, t, t2, e, r, u;
      int val;
      split_coord(wx, model_scale, cx0, fx);
      split_coord(wy, model_scale, cy0, fy);
      d1 = '1;
      d2 = '1;
      bx = cx0;
      by = cy0;
      for (int oy = -1; oy <= 1; oy++) begin
         for (int ox = -1; ox <= 1; ox++) begin
            cx = cx0 + 32'(ox);
            cy = cy0 + 32'(oy);
            dx = longint'(ox) * 16777216 + place_offset(mix_hash(cx, cy, SALT_FX)) - fx;
            dy = longint'(oy) * 16777216 + place_offset(mix_hash(cx, cy, SALT_FY)) - fy;
            dd = dx * dx + dy * dy;
            if (dd < d1) begin
               d2 = d1;
               d1 = dd;
               bx = cx;
               by = cy;
            end else if (dd < d2) begin
               d2 = dd;
            end
         end
      end
      sep = isqrt(d2) - isqrt(d1);
      if (sep <= 301990) begin
         t = 0;
      end else begin
         t = ((sep - 301990) << 16) / 2013266;
         if (t > 65536) t = 65536;
      end
      t2 = (t * t) >> 16;
      e = (t2 * (196608 - 2 * t)) >> 16;
      u = mix_hash(bx, by, SALT_REGION) >> 8;
      r = 64'd4194304 + ((u * 64'd23488102) >> 24);
      val = -31130 + int'((r * e + (64'd1 << 24)) >> 25);
      return 16'(val);
   endfunction

   // Directed rows: world x, world y, an optional typed-in expectation.
   typedef struct {
      logic [31:0] wx;
      logic [31:0] wy;
      bit          has_fixed;
      logic signed [15:0] fixed_val;
   } probe_row_type;

   // Sends one beat and records its expectation; the valid drops after the last beat and in random gaps when not calm.
   task automatic send_beat(input logic [31:0] wx, input logic [31:0] wy,
                            input logic signed [15:0] exp_val, input bit last);
      req_tvalid <= 1'b1;
      req_tdata <= {wy, wx};
      field_queue.push_back(exp_val);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent++;
      if (last || (!calm && $urandom_range(99) < 7)) begin
         req_tvalid <= 1'b0;
         if (!last) begin
            repeat ($urandom_range(3, 1)) @(posedge clock);
         end
      end
   endtask

   task automatic write_scale(input logic [18:0] value);
      while (field_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      model_scale = value;
   endtask

   task automatic random_burst(input int count);
      logic [31:0] wx, wy;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(3))
            0: begin
               wx = $urandom;
               wy = $urandom;
            end
            1: begin
               wx = 32'($signed($urandom_range(2000)) - 1000) <<< 14;
               wy = 32'($signed($urandom_range(2000)) - 1000) <<< 14;
            end
            2: begin
               wx = {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
               wy = {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            end
            default: begin
               wx = $urandom_range(1) ? 32'h7FFF_0000 + $urandom_range(65535)
                                      : 32'h8000_0000 + $urandom_range(65535);
               wy = $urandom;
            end
         endcase
         send_beat(wx, wy, predict_field(wx, wy), i == count - 1);
      end
   endtask

   // Checks each response beat against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         received <= received + 1;
         if (field_queue.size() == 0) begin
            $display("%0t: unexpected field_value beat, expected none, actual %0d",
                     $time, $signed(rsp_tdata));
            errors <= errors + 1;
         end else begin
            if (rsp_tdata !== field_queue[0]) begin
               $display("%0t: field_value mismatch, expected %0d, actual %0d",
                        $time, field_queue[0], $signed(rsp_tdata));
               errors <= errors + 1;
            end
            void'(field_queue.pop_front());
         end
      end
   end

   // Response side: random stalls, none while calm, and one long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !rsp_hold && (calm || $urandom_range(99) >= 7);
      end
   end

   // Watchdog on cycles with no accepted beat on any channel.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 5000) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   initial begin
      probe_row_type rows[$];
      logic [18:0] scales[6];
      rows.push_back('{32'h0000_0000, 32'h0000_0000, 1'b0, 16'sd0});
      rows.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 16'sd0});
      rows.push_back('{32'h8000_0000, 32'h8000_0000, 1'b0, 16'sd0});
      rows.push_back('{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 16'sd0});
      rows.push_back('{32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 16'sd0});
      rows.push_back('{32'h0001_0000, 32'hFFFF_0000, 1'b0, 16'sd0});
      rows.push_back('{32'h0000_8000, 32'h0000_8000, 1'b0, 16'sd0});
      rows.push_back('{32'hFFFF_8000, 32'h0003_4000, 1'b0, 16'sd0});
      rows.push_back('{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 16'sd0});
      rows.push_back('{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 16'sd0});
      rows.push_back('{32'h0000_FFFF, 32'hFFFF_0001, 1'b0, 16'sd0});
      rows.push_back('{32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 16'sd0});
      scales = '{19'd262144, 19'd1, 19'd0, 19'h7FFFF, 19'd98304, 19'd65536};

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table at the reset scale of 1.0.
      foreach (rows[i]) begin
         send_beat(rows[i].wx, rows[i].wy,
                   rows[i].has_fixed ? rows[i].fixed_val
                                     : predict_field(rows[i].wx, rows[i].wy),
                   i == rows.size() - 1);
      end
      random_burst(200);

      // Long response hold-off while the request side keeps offering beats.
      fork
         begin
            rsp_hold = 1'b1;
            repeat (200) @(posedge clock);
            rsp_hold = 1'b0;
         end
         random_burst(120);
      join

      calm = 1'b1;
      random_burst(180);
      calm = 1'b0;

      // Scale settings, the extremes among them, each with directed and random beats.
      foreach (scales[k]) begin
         write_scale(scales[k]);
         foreach (rows[i]) begin
            send_beat(rows[i].wx, rows[i].wy, predict_field(rows[i].wx, rows[i].wy),
                      i == rows.size() - 1);
         end
         random_burst(130);
      end

      while (field_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      $display("Sent %0d request beats over %0d cell scales, including a long response stall.",
               sent, 7);
      if (errors == 0 && received == sent) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
